// ===== rtl/pearson_correlation_stats_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the correlation statistics block
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef PEARSON_CORRELATION_STATS_ASSERT_SVH
`define PEARSON_CORRELATION_STATS_ASSERT_SVH

// property holds in the same cycle
`define PCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pcs assertion failed");

// cause in one cycle, effect in the next
`define PCS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pcs assertion failed");

`endif

// ===== rtl/pcs_pkg.sv =====
// ---------------------------------------------------------------------------
// pcs_pkg
// Types, widths and codes shared by the correlation statistics block.
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int CNT_W  = 11;
    localparam int SUM_W  = 27;
    localparam int SQ_W   = 42;
    localparam int COV_W  = 40;
    localparam int CORR_W = 16;

    // back-end datapath widths
    localparam int OP_W   = 53;
    localparam int PROD_W = 2 * OP_W;
    localparam int DVD_W  = 136;
    localparam int DVS_W  = 103;
    localparam int QUO_W  = 64;
    localparam int RAD_W  = 34;
    localparam int ROOT_W = 17;
    localparam int SREM_W = 19;

    localparam logic [QUO_W-1:0] COV_MAX = 64'd549755813887;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_ZVAR = 2'd2;
    localparam logic [1:0] STAT_DROP = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M_NXX,
        ST_M_XX,
        ST_M_NYY,
        ST_M_YY,
        ST_M_NXY,
        ST_M_XY,
        ST_DIV_COV,
        ST_M_PROD,
        ST_M_SQ,
        ST_DIV_COR,
        ST_SQRT,
        ST_DONE
    } t_state;

    // sums captured for one report
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic [SQ_W-1:0]         sxx;
        logic [SQ_W-1:0]         syy;
        logic signed [SQ_W-1:0]  sxy;
        logic                    ovf;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/pcs_if.sv =====
// ---------------------------------------------------------------------------
// pcs_in_if / pcs_out_if
// Valid/ready channels for sample beats and report beats.
// ---------------------------------------------------------------------------
interface pcs_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic        report;
    logic        end_of_set;

    modport source (output valid, x_sample, y_sample, report, end_of_set, input ready);
    modport sink   (input valid, x_sample, y_sample, report, end_of_set, output ready);
endinterface

interface pcs_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] sample_count;
    logic signed [39:0] covariance;
    logic signed [15:0] correlation;
    logic [1:0]  status;

    modport source (output valid, sample_count, covariance, correlation, status,
                    input ready);
    modport sink   (input valid, sample_count, covariance, correlation, status,
                    output ready);
endinterface

// ===== rtl/pcs_front.sv =====
// ---------------------------------------------------------------------------
// pcs_front
// Accepts sample beats, keeps the running sums, pushes a snapshot on report.
// ---------------------------------------------------------------------------
module pcs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pcs_in_if.sink               i_in,
    input  pcs_pkg::t_q_stat     i_q_stat,
    output logic                 o_push,
    output pcs_pkg::t_snap       o_snap
);

    logic [pcs_pkg::CNT_W-1:0]        r_count, n_count;
    logic signed [pcs_pkg::SUM_W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic [pcs_pkg::SQ_W-1:0]         r_sxx, n_sxx, r_syy, n_syy;
    logic signed [pcs_pkg::SQ_W-1:0]  r_sxy, n_sxy;
    logic                             r_ovf, n_ovf;

    logic signed [pcs_pkg::SAMPLE_BITS-1:0]   x, y;
    logic signed [2*pcs_pkg::SAMPLE_BITS-1:0] pxx, pyy, pxy;
    logic accept;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    assign x   = i_in.x_sample[pcs_pkg::SAMPLE_BITS-1:0];
    assign y   = i_in.y_sample[pcs_pkg::SAMPLE_BITS-1:0];
    assign pxx = x * x;
    assign pyy = y * y;
    assign pxy = x * y;

    always_comb begin
        n_count = r_count;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_sxx   = r_sxx;
        n_syy   = r_syy;
        n_sxy   = r_sxy;
        n_ovf   = r_ovf;
        if (r_count < pcs_pkg::CNT_W'(pcs_pkg::MAX_SAMPLES)) begin
            n_count = r_count + 1'b1;
            n_sx    = r_sx + pcs_pkg::SUM_W'(x);
            n_sy    = r_sy + pcs_pkg::SUM_W'(y);
            n_sxx   = r_sxx + pcs_pkg::SQ_W'($unsigned(pxx));
            n_syy   = r_syy + pcs_pkg::SQ_W'($unsigned(pyy));
            n_sxy   = r_sxy + pcs_pkg::SQ_W'(pxy);
        end else begin
            n_ovf = 1'b1;
        end
    end

    assign o_push       = accept && i_in.report;
    assign o_snap.count = n_count;
    assign o_snap.sx    = n_sx;
    assign o_snap.sy    = n_sy;
    assign o_snap.sxx   = n_sxx;
    assign o_snap.syy   = n_syy;
    assign o_snap.sxy   = n_sxy;
    assign o_snap.ovf   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.end_of_set)) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_sxx   <= n_sxx;
            r_syy   <= n_syy;
            r_sxy   <= n_sxy;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== rtl/pcs_queue.sv =====
// ---------------------------------------------------------------------------
// pcs_queue
// Two-entry snapshot queue between the accumulator and the report engine.
// ---------------------------------------------------------------------------
module pcs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcs_pkg::t_snap   i_snap,
    input  logic             i_pop,
    output pcs_pkg::t_snap   o_head,
    output pcs_pkg::t_q_stat o_stat
);

    pcs_pkg::t_snap r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_fill;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_fill == 2'd2);
    assign o_stat.empty = (r_fill == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            if (i_push && !i_pop)      r_fill <= r_fill + 2'd1;
            else if (i_pop && !i_push) r_fill <= r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_snap;
    end

endmodule

// ===== rtl/pcs_back.sv =====
// ---------------------------------------------------------------------------
// pcs_back
// Report engine: shift-add multiplier, restoring divider and digit-by-digit
// square root run in sequence over one snapshot, result held in a register.
// ---------------------------------------------------------------------------
`include "pearson_correlation_stats_assert.svh"

module pcs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcs_pkg::t_snap   i_head,
    input  pcs_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    pcs_out_if.source        o_out
);

    pcs_pkg::t_state r_state, n_state;
    logic            r_run;
    pcs_pkg::t_snap  r_snap;

    logic [pcs_pkg::PROD_W-1:0] r_ma, r_acc;
    logic [pcs_pkg::OP_W-1:0]   r_mb;
    logic [pcs_pkg::OP_W-1:0]   r_dxx, r_dyy;
    logic signed [pcs_pkg::OP_W-1:0] r_dxy;

    logic [pcs_pkg::DVD_W-1:0]  r_dvd;
    logic [pcs_pkg::DVS_W-1:0]  r_dvs, r_rem;
    logic [pcs_pkg::QUO_W-1:0]  r_quo;
    logic [7:0]                 r_cnt;

    logic [pcs_pkg::RAD_W-1:0]  r_rad;
    logic [pcs_pkg::ROOT_W-1:0] r_root;
    logic [pcs_pkg::SREM_W-1:0] r_srem;

    logic signed [pcs_pkg::COV_W-1:0]  r_cov;
    logic signed [pcs_pkg::CORR_W-1:0] r_corr;
    logic [1:0]                        r_status;

    logic                              r_out_valid;
    logic [pcs_pkg::CNT_W-1:0]         r_out_count;
    logic signed [pcs_pkg::COV_W-1:0]  r_out_cov;
    logic signed [pcs_pkg::CORR_W-1:0] r_out_corr;
    logic [1:0]                        r_out_status;

    logic out_load, unit_done, is_mul, zero_var;
    logic [pcs_pkg::OP_W-1:0] mul_a, mul_b, prod53, dxy_mag;
    logic [pcs_pkg::SUM_W-1:0] sx_mag, sy_mag;
    logic [pcs_pkg::SQ_W-1:0]  sxy_mag;
    logic [2*pcs_pkg::CNT_W-1:0] den;
    logic [pcs_pkg::DVS_W:0]   rem_sh;
    logic                      div_ge;
    logic [pcs_pkg::SREM_W+1:0] srem_sh, trial;
    logic                      sq_ge;
    logic [pcs_pkg::ROOT_W:0]  m_ext;
    logic [pcs_pkg::ROOT_W-1:0] m_val;
    logic dxy_neg;

    assign sx_mag  = r_snap.sx[pcs_pkg::SUM_W-1] ? -r_snap.sx : r_snap.sx;
    assign sy_mag  = r_snap.sy[pcs_pkg::SUM_W-1] ? -r_snap.sy : r_snap.sy;
    assign sxy_mag = r_snap.sxy[pcs_pkg::SQ_W-1] ? -r_snap.sxy : r_snap.sxy;
    assign dxy_neg = r_dxy[pcs_pkg::OP_W-1];
    assign dxy_mag = dxy_neg ? -r_dxy : r_dxy;
    assign prod53  = r_acc[pcs_pkg::OP_W-1:0];
    assign den     = r_snap.count * (r_snap.count - 1'b1);
    assign zero_var = (r_dxx == '0) || (r_dyy == '0);

    assign rem_sh  = {r_rem, r_dvd[pcs_pkg::DVD_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_dvs};
    assign srem_sh = {r_srem, r_rad[pcs_pkg::RAD_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign sq_ge   = srem_sh >= trial;
    assign m_ext   = ({1'b0, r_root} + 1'b1) >> 1;
    assign m_val   = m_ext[pcs_pkg::ROOT_W-1:0];

    always_comb begin
        is_mul = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            pcs_pkg::ST_M_NXX: begin
                is_mul = 1'b1;
                mul_a  = pcs_pkg::OP_W'(r_snap.count);
                mul_b  = pcs_pkg::OP_W'(r_snap.sxx);
            end
            pcs_pkg::ST_M_XX: begin
                is_mul = 1'b1;
                mul_a  = pcs_pkg::OP_W'(sx_mag);
                mul_b  = pcs_pkg::OP_W'(sx_mag);
            end
            pcs_pkg::ST_M_NYY: begin
                is_mul = 1'b1;
                mul_a  = pcs_pkg::OP_W'(r_snap.count);
                mul_b  = pcs_pkg::OP_W'(r_snap.syy);
            end
            pcs_pkg::ST_M_YY: begin
                is_mul = 1'b1;
                mul_a  = pcs_pkg::OP_W'(sy_mag);
                mul_b  = pcs_pkg::OP_W'(sy_mag);
            end
            pcs_pkg::ST_M_NXY: begin
                is_mul = 1'b1;
                mul_a  = pcs_pkg::OP_W'(r_snap.count);
                mul_b  = pcs_pkg::OP_W'(sxy_mag);
            end
            pcs_pkg::ST_M_XY: begin
                is_mul = 1'b1;
                mul_a  = pcs_pkg::OP_W'(sx_mag);
                mul_b  = pcs_pkg::OP_W'(sy_mag);
            end
            pcs_pkg::ST_M_PROD: begin
                is_mul = 1'b1;
                mul_a  = r_dxx;
                mul_b  = r_dyy;
            end
            pcs_pkg::ST_M_SQ: begin
                is_mul = 1'b1;
                mul_a  = dxy_mag;
                mul_b  = dxy_mag;
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            pcs_pkg::ST_DIV_COV, pcs_pkg::ST_DIV_COR, pcs_pkg::ST_SQRT:
                unit_done = (r_cnt == 8'd0);
            default:
                unit_done = is_mul && (r_mb == '0);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = (i_head.count < pcs_pkg::CNT_W'(2)) ? pcs_pkg::ST_DONE
                                                                   : pcs_pkg::ST_M_NXX;
                end
            end
            pcs_pkg::ST_M_NXX: if (r_run && unit_done) n_state = pcs_pkg::ST_M_XX;
            pcs_pkg::ST_M_XX:  if (r_run && unit_done) n_state = pcs_pkg::ST_M_NYY;
            pcs_pkg::ST_M_NYY: if (r_run && unit_done) n_state = pcs_pkg::ST_M_YY;
            pcs_pkg::ST_M_YY:  if (r_run && unit_done) n_state = pcs_pkg::ST_M_NXY;
            pcs_pkg::ST_M_NXY: if (r_run && unit_done) n_state = pcs_pkg::ST_M_XY;
            pcs_pkg::ST_M_XY:  if (r_run && unit_done) n_state = pcs_pkg::ST_DIV_COV;
            pcs_pkg::ST_DIV_COV: begin
                if (r_run && unit_done)
                    n_state = zero_var ? pcs_pkg::ST_DONE : pcs_pkg::ST_M_PROD;
            end
            pcs_pkg::ST_M_PROD:  if (r_run && unit_done) n_state = pcs_pkg::ST_M_SQ;
            pcs_pkg::ST_M_SQ:    if (r_run && unit_done) n_state = pcs_pkg::ST_DIV_COR;
            pcs_pkg::ST_DIV_COR: if (r_run && unit_done) n_state = pcs_pkg::ST_SQRT;
            pcs_pkg::ST_SQRT:    if (r_run && unit_done) n_state = pcs_pkg::ST_DONE;
            pcs_pkg::ST_DONE:    if (out_load) n_state = pcs_pkg::ST_IDLE;
            default:             n_state = pcs_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop    = (r_state == pcs_pkg::ST_IDLE) && !i_q_stat.empty;
        out_load = (r_state == pcs_pkg::ST_DONE) && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcs_pkg::ST_IDLE;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pcs_pkg::ST_IDLE || r_state == pcs_pkg::ST_DONE)
                r_run <= 1'b0;
            else if (!r_run)
                r_run <= 1'b1;
            else if (unit_done)
                r_run <= 1'b0;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_snap <= i_head;
            if (i_head.count < pcs_pkg::CNT_W'(2)) begin
                r_cov    <= '0;
                r_corr   <= '0;
                r_status <= pcs_pkg::STAT_FEW;
            end
        end

        // shared shift-add multiplier
        if (is_mul) begin
            if (!r_run) begin
                r_ma  <= pcs_pkg::PROD_W'(mul_a);
                r_mb  <= mul_b;
                r_acc <= '0;
            end else if (!unit_done) begin
                if (r_mb[0]) r_acc <= r_acc + r_ma;
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end else begin
                case (r_state)
                    pcs_pkg::ST_M_NXX: r_dxx <= prod53;
                    pcs_pkg::ST_M_XX:  r_dxx <= r_dxx - prod53;
                    pcs_pkg::ST_M_NYY: r_dyy <= prod53;
                    pcs_pkg::ST_M_YY:  r_dyy <= r_dyy - prod53;
                    pcs_pkg::ST_M_NXY:
                        r_dxy <= r_snap.sxy[pcs_pkg::SQ_W-1] ? -prod53 : prod53;
                    pcs_pkg::ST_M_XY:
                        r_dxy <= (r_snap.sx[pcs_pkg::SUM_W-1] ^ r_snap.sy[pcs_pkg::SUM_W-1])
                                 ? r_dxy + prod53 : r_dxy - prod53;
                    // divisor for the correlation step comes straight off the multiplier
                    pcs_pkg::ST_M_PROD: r_dvs <= r_acc[pcs_pkg::DVS_W-1:0];
                    default: ;
                endcase
            end
        end

        // restoring divider, one quotient bit a cycle
        if (r_state == pcs_pkg::ST_DIV_COV || r_state == pcs_pkg::ST_DIV_COR) begin
            if (!r_run) begin
                if (r_state == pcs_pkg::ST_DIV_COV) begin
                    r_dvd <= (pcs_pkg::DVD_W'(dxy_mag) << 9) + pcs_pkg::DVD_W'(den);
                    r_dvs <= pcs_pkg::DVS_W'(den) << 1;
                end else begin
                    // dividend Dxy^2 * 2^32, divisor Dxx*Dyy kept in r_dvs
                    r_dvd <= {r_acc[pcs_pkg::DVD_W-33:0], 32'd0};
                end
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 8'(pcs_pkg::DVD_W);
            end else if (!unit_done) begin
                r_rem <= div_ge ? pcs_pkg::DVS_W'(rem_sh - {1'b0, r_dvs})
                                : rem_sh[pcs_pkg::DVS_W-1:0];
                r_quo <= {r_quo[pcs_pkg::QUO_W-2:0], div_ge};
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 8'd1;
            end else if (r_state == pcs_pkg::ST_DIV_COV) begin
                if (r_quo > pcs_pkg::COV_MAX)
                    r_cov <= dxy_neg ? {1'b1, {(pcs_pkg::COV_W-1){1'b0}}}
                                     : {1'b0, {(pcs_pkg::COV_W-1){1'b1}}};
                else
                    r_cov <= dxy_neg ? -r_quo[pcs_pkg::COV_W-1:0]
                                     : r_quo[pcs_pkg::COV_W-1:0];
                r_corr <= '0;
                if (r_snap.ovf)    r_status <= pcs_pkg::STAT_DROP;
                else if (zero_var) r_status <= pcs_pkg::STAT_ZVAR;
                else               r_status <= pcs_pkg::STAT_OK;
            end
        end

        // integer square root, one result bit a cycle
        if (r_state == pcs_pkg::ST_SQRT) begin
            if (!r_run) begin
                r_rad  <= r_quo[pcs_pkg::RAD_W-1:0];
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= 8'(pcs_pkg::ROOT_W);
            end else if (!unit_done) begin
                r_srem <= sq_ge ? pcs_pkg::SREM_W'(srem_sh - trial)
                                : srem_sh[pcs_pkg::SREM_W-1:0];
                r_root <= {r_root[pcs_pkg::ROOT_W-2:0], sq_ge};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - 8'd1;
            end else begin
                // m = ceil(root/2); full scale only reachable for negative r
                if (dxy_neg)
                    r_corr <= -m_val[pcs_pkg::CORR_W-1:0];
                else if (m_val > pcs_pkg::ROOT_W'(32767))
                    r_corr <= {1'b0, {(pcs_pkg::CORR_W-1){1'b1}}};
                else
                    r_corr <= m_val[pcs_pkg::CORR_W-1:0];
            end
        end

        if (out_load) begin
            r_out_count  <= r_snap.count;
            r_out_cov    <= r_cov;
            r_out_corr   <= r_corr;
            r_out_status <= r_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_count = r_out_count;
    assign o_out.covariance   = r_out_cov;
    assign o_out.correlation  = r_out_corr;
    assign o_out.status       = r_out_status;

    `PCS_ASSERT(a_pop_when_idle, !o_pop || (r_state == pcs_pkg::ST_IDLE))
    `PCS_ASSERT_NEXT(a_pop_leaves_idle, o_pop, r_state != pcs_pkg::ST_IDLE)
    `PCS_ASSERT(a_few_is_zero, !(r_out_valid && (r_out_status == pcs_pkg::STAT_FEW)) ||
                ((r_out_cov == '0) && (r_out_corr == '0)))
    `PCS_ASSERT(a_zvar_corr_zero, !(r_out_valid && (r_out_status == pcs_pkg::STAT_ZVAR)) ||
                (r_out_corr == '0))

endmodule

// ===== rtl/pearson_correlation_stats.sv =====
// ---------------------------------------------------------------------------
// pearson_correlation_stats
// Running sums over paired samples with covariance and Pearson reports.
// ---------------------------------------------------------------------------
// Sample beats are taken one per cycle while input ready is high; each one
// updates the exact sums in the same cycle. A beat with report set also
// pushes a snapshot of the sums into a two-entry queue, and input ready
// drops only while that queue is full. The report engine works one snapshot
// at a time: eight products on a shared shift-add multiplier, two passes of
// a restoring divider and a square root; the last two products, the second
// division and the root are skipped when a variance is zero, and all of them
// when under two pairs are held. The result sits in an output register, so
// the next snapshot can start meanwhile.
// ---------------------------------------------------------------------------
module pearson_correlation_stats (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcs_in_if.sink     i_in,
    pcs_out_if.source  o_out
);

    logic             push, pop;
    pcs_pkg::t_snap   snap_in, snap_head;
    pcs_pkg::t_q_stat q_stat;

    pcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_snap   (snap_in)
    );

    pcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_snap  (snap_in),
        .i_pop   (pop),
        .o_head  (snap_head),
        .o_stat  (q_stat)
    );

    pcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (snap_head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
